FILE: hw/rtl/zdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdf_pkg: shared types, codes and helpers of the ladder lowpass filter
// Register indexes, rounding modes of the shared multiplier, the table
// lookup record and the saturation helper used across the block.
// ----------------------------------------------------------------------------
package zdf_pkg;

  // datapath widths of the shared unit
  localparam int unsigned OpAWidth = 40;
  localparam int unsigned OpBWidth = 17;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STAGE_GAIN    = 3'd0,
    CFG_RESONANCE     = 3'd1,
    CFG_FEEDBACK_NORM = 3'd2,
    CFG_DRIVE_GAIN    = 3'd3,
    CFG_DRIVE_NORM    = 3'd4,
    CFG_SATURATE_MODE = 3'd5
  } cfg_idx_e;

  // rounding or truncating shift applied to the product of the shared multiplier
  typedef enum logic [1:0] {
    RND_SH16   = 2'd0,
    RND_SH14   = 2'd1,
    TRUNC_SH16 = 2'd2,
    RND_SHY    = 2'd3
  } rnd_e;

  // result of the shaping table lookup
  typedef struct packed {
    logic        neg;
    logic [30:0] t0;
    logic [30:0] dif;
    logic [15:0] frac;
  } sat_lk_t;

  // clamp a wide signed value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [OpAWidth-1:0] v);
    logic signed [OpAWidth-1:0] hi;
    logic signed [OpAWidth-1:0] lo;
    hi = OpAWidth'(64'sh7FFF_FFFF);
    lo = -hi - OpAWidth'(64'sd1);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return 32'(v);
  endfunction

endpackage

FILE: hw/rtl/zdf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdf_if: sample channels of the ladder lowpass filter
// Valid/ready channels carrying one input sample and one filtered sample.
// ----------------------------------------------------------------------------
interface zdf_in_if #(
  parameter int unsigned SampleWidth = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface zdf_out_if #(
  parameter int unsigned SampleWidth = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/zdf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdf_mul: shared multiply and round unit
// Signed 40 bit by unsigned 17 bit product, then a rounding or truncating
// arithmetic right shift selected by the sequencer.
// ----------------------------------------------------------------------------
module zdf_mul #(
  parameter int unsigned SampleWidth = 24
) (
  input  logic signed [zdf_pkg::OpAWidth-1:0] a_i,
  input  logic        [zdf_pkg::OpBWidth-1:0] b_i,
  input  zdf_pkg::rnd_e                       mode_i,
  output logic signed [zdf_pkg::OpAWidth-1:0] r_o
);
  localparam int unsigned PW  = zdf_pkg::OpAWidth + zdf_pkg::OpBWidth + 1;
  localparam int unsigned ShY = 43 - (SampleWidth - 1);

  logic signed [PW-1:0] prod;

  // one multiplier for every step
  assign prod = a_i * $signed({1'b0, b_i});

  // rounding or truncating shift
  always_comb begin
    case (mode_i)
      zdf_pkg::RND_SH16:   r_o = zdf_pkg::OpAWidth'((prod + (PW'(1) <<< 15)) >>> 16);
      zdf_pkg::RND_SH14:   r_o = zdf_pkg::OpAWidth'((prod + (PW'(1) <<< 13)) >>> 14);
      zdf_pkg::TRUNC_SH16: r_o = zdf_pkg::OpAWidth'(prod >>> 16);
      zdf_pkg::RND_SHY:    r_o = zdf_pkg::OpAWidth'((prod + (PW'(1) <<< (ShY - 1))) >>> ShY);
      default:             r_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/zdf_sat_tab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdf_sat_tab: tanh shaping table lookup
// Splits the driven magnitude into table index and fraction and reads the
// two neighbouring entries of the constant tanh table.
// ----------------------------------------------------------------------------
module zdf_sat_tab #(
  parameter int unsigned SampleWidth   = 24,
  parameter int unsigned SatTableDepth = 256
) (
  input  logic signed [zdf_pkg::OpAWidth-1:0] drive_i,
  output zdf_pkg::sat_lk_t                    lk_o
);
  localparam int unsigned Frac = SampleWidth - 1;
  localparam int unsigned IW   = $clog2(SatTableDepth + 1);
  localparam int unsigned PW   = zdf_pkg::OpAWidth + IW;
  localparam longint unsigned One = 64'd1 << 30;

  logic [30:0]                   tab [SatTableDepth+1];
  logic [zdf_pkg::OpAWidth-1:0]  mag;
  logic [PW-1:0]                 pos;
  logic [PW-1:0]                 idx_full;
  logic                          over;
  logic [IW-1:0]                 idx0;
  logic [IW-1:0]                 idx1;

  // constant table, worked out at elaboration
  // Q0.30 tanh(4k/depth): series at 1/64 of the argument, then six doublings
  for (genvar k = 0; k <= SatTableDepth; k++) begin : g_tab
    localparam longint unsigned Y  = (64'(k) << 32) / (64'(SatTableDepth) * 64'd64);
    localparam longint unsigned Y2 = (Y * Y) >> 30;
    localparam longint unsigned Y3 = (Y2 * Y) >> 30;
    localparam longint unsigned Y5 = (Y3 * Y2) >> 30;
    localparam longint unsigned Y7 = (Y5 * Y2) >> 30;
    localparam longint unsigned T0 =
      Y - Y3 / 64'd3 + (64'd2 * Y5) / 64'd15 - (64'd17 * Y7) / 64'd315;
    localparam longint unsigned D0 = One + ((T0 * T0) >> 30);
    localparam longint unsigned T1 = (T0 << 31) / D0;
    localparam longint unsigned D1 = One + ((T1 * T1) >> 30);
    localparam longint unsigned T2 = (T1 << 31) / D1;
    localparam longint unsigned D2 = One + ((T2 * T2) >> 30);
    localparam longint unsigned T3 = (T2 << 31) / D2;
    localparam longint unsigned D3 = One + ((T3 * T3) >> 30);
    localparam longint unsigned T4 = (T3 << 31) / D3;
    localparam longint unsigned D4 = One + ((T4 * T4) >> 30);
    localparam longint unsigned T5 = (T4 << 31) / D4;
    localparam longint unsigned D5 = One + ((T5 * T5) >> 30);
    localparam longint unsigned T6 = (T5 << 31) / D5;
    localparam longint unsigned Val = (T6 > One) ? One : T6;
    assign tab[k] = 31'(Val);
  end

  // magnitude, index and fraction
  assign mag      = drive_i[zdf_pkg::OpAWidth-1] ? zdf_pkg::OpAWidth'(-drive_i)
                                                 : zdf_pkg::OpAWidth'(drive_i);
  assign pos      = PW'(mag) * PW'(SatTableDepth);
  assign idx_full = pos >> (Frac + 2);
  assign over     = idx_full >= PW'(SatTableDepth);
  assign idx0     = over ? IW'(SatTableDepth) : idx_full[IW-1:0];
  assign idx1     = over ? idx0 : IW'(idx0 + IW'(1));

  // neighbouring entries
  assign lk_o.neg  = drive_i[zdf_pkg::OpAWidth-1];
  assign lk_o.t0   = tab[idx0];
  assign lk_o.dif  = tab[idx1] - tab[idx0];
  assign lk_o.frac = 16'(pos[Frac+1:0] >> (Frac - 14));

endmodule

FILE: hw/rtl/zdf_ladder_lowpass_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdf_ladder_lowpass_filter_top: four-pole zero-delay-feedback ladder lowpass
// Sequencer around one shared multiplier computing resonance feedback and
// four one-pole stages with optional tanh shaping.
// ----------------------------------------------------------------------------
// Usage
//   in_i carries one signed Q1.23 sample per transfer; out_o returns one
//   filtered, saturated sample per input, in order.
//   cfg_we_i / cfg_idx_i / cfg_data_i write the six filter registers; write
//   them only while no sample is in flight. Unknown indexes are ignored.
// Timing
//   Every multiply goes through the one shared multiplier, one per cycle.
//   A sample runs through the feedback estimate and input scaling, then the
//   four stages in order (with the tanh shaping steps in saturate mode), then
//   the result. A new sample is taken only once the sequencer is idle again.
//   in_i.ready is high only while the sequencer is idle.
// Reset
//   Configuration registers take their defaults and the stage memories clear.
// Stall
//   The result sits in an output register; the next sample is taken while it
//   waits. A finished sample waits in the sequencer until that register frees.
// ----------------------------------------------------------------------------
module zdf_ladder_lowpass_filter_top #(
  parameter int unsigned SAT_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH    = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  zdf_in_if.sink      in_i,
  zdf_out_if.source   out_o
);
  localparam int unsigned AW = zdf_pkg::OpAWidth;
  localparam logic signed [31:0] OutHi = 32'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [31:0] OutLo = -OutHi - 32'sd1;

  typedef enum logic [18:0] {
    ST_IDLE = 19'h00001,
    ST_SI   = 19'h00002,
    ST_HMUL = 19'h00004,
    ST_HADD = 19'h00008,
    ST_QS   = 19'h00010,
    ST_DIFF = 19'h00020,
    ST_NORM = 19'h00040,
    ST_SUB  = 19'h00080,
    ST_D    = 19'h00100,
    ST_A    = 19'h00200,
    ST_LK   = 19'h00400,
    ST_INT  = 19'h00800,
    ST_Y    = 19'h01000,
    ST_SGN  = 19'h02000,
    ST_E    = 19'h04000,
    ST_O    = 19'h08000,
    ST_OUT  = 19'h10000,
    ST_MEM  = 19'h20000,
    ST_DONE = 19'h40000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] gain_q, res_q, dg_q, dn_q;
  logic [16:0] fbn_q;
  logic        sat_q;

  // working registers
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [31:0]             mem_q [4];
  logic signed [32:0]             s_q [4];
  logic signed [AW-1:0]           acc_q, t_q;
  logic signed [31:0]             v_q, drv_q;
  logic signed [33:0]             d_q;
  logic signed [32:0]             e_q;
  logic                           neg_q;
  logic [30:0]                    t0_q, dif_q;
  logic [15:0]                    f_q;
  logic [1:0]                     cnt_q;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic signed [AW-1:0]                mul_a, mul_r;
  logic [zdf_pkg::OpBWidth-1:0]        mul_b;
  zdf_pkg::rnd_e                       mul_mode;
  zdf_pkg::sat_lk_t                    lk;
  logic                                out_free;
  logic signed [31:0]                  out_sat;

  assign in_i.ready    = state_q == ST_IDLE;
  assign out_o.valid   = out_valid_q;
  assign out_o.sample_out = out_q;
  assign out_free      = !out_valid_q || out_o.ready;

  // shared multiplier
  zdf_mul #(.SampleWidth(SAMPLE_WIDTH)) u_mul (
    .a_i   (mul_a),
    .b_i   (mul_b),
    .mode_i(mul_mode),
    .r_o   (mul_r)
  );

  // shaping table
  zdf_sat_tab #(.SampleWidth(SAMPLE_WIDTH), .SatTableDepth(SAT_TABLE_DEPTH)) u_tab (
    .drive_i(t_q),
    .lk_o   (lk)
  );

  // operand selection per step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_mode = zdf_pkg::RND_SH16;
    unique case (state_q)
      ST_SI: begin
        mul_a = AW'(mem_q[cnt_q]);
        mul_b = 17'h10000 - 17'(gain_q);
      end
      ST_HMUL: begin
        mul_a = acc_q;
        mul_b = 17'(gain_q);
      end
      ST_QS: begin
        mul_a    = acc_q;
        mul_b    = 17'(res_q);
        mul_mode = zdf_pkg::RND_SH14;
      end
      ST_NORM: begin
        mul_a = acc_q;
        mul_b = fbn_q;
      end
      ST_D, ST_O: begin
        mul_a = AW'(e_q);
        mul_b = 17'(gain_q);
      end
      ST_A: begin
        mul_a    = AW'(v_q);
        mul_b    = 17'(dg_q);
        mul_mode = zdf_pkg::RND_SH14;
      end
      ST_INT: begin
        mul_a    = AW'({1'b0, dif_q});
        mul_b    = 17'(f_q);
        mul_mode = zdf_pkg::TRUNC_SH16;
      end
      ST_Y: begin
        mul_a    = t_q;
        mul_b    = 17'(dn_q);
        mul_mode = zdf_pkg::RND_SHY;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // step sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_SI;
      ST_SI:   if (cnt_q == 2'd3) state_d = ST_HMUL;
      ST_HMUL: state_d = ST_HADD;
      ST_HADD: state_d = (cnt_q == 2'd3) ? ST_QS : ST_HMUL;
      ST_QS:   state_d = ST_DIFF;
      ST_DIFF: state_d = ST_NORM;
      ST_NORM: state_d = ST_SUB;
      ST_SUB:  state_d = ST_D;
      ST_D:    state_d = sat_q ? ST_A : ST_E;
      ST_A:    state_d = ST_LK;
      ST_LK:   state_d = ST_INT;
      ST_INT:  state_d = ST_Y;
      ST_Y:    state_d = ST_SGN;
      ST_SGN:  state_d = ST_E;
      ST_E:    state_d = ST_O;
      ST_O:    state_d = ST_OUT;
      ST_OUT:  state_d = ST_MEM;
      ST_MEM:  state_d = (cnt_q == 2'd3) ? ST_DONE : ST_SUB;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // final clamp to the sample range
  assign out_sat = (v_q > OutHi) ? OutHi : ((v_q < OutLo) ? OutLo : v_q);

  // control state, configuration and stage memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= 16'd16384;
      res_q       <= 16'd0;
      fbn_q       <= 17'd65536;
      dg_q        <= 16'd5461;
      dn_q        <= 16'd25481;
      sat_q       <= 1'b0;
      for (int i = 0; i < 4; i++) mem_q[i] <= '0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          zdf_pkg::CFG_STAGE_GAIN:    gain_q <= cfg_data_i[15:0];
          zdf_pkg::CFG_RESONANCE:     res_q  <= cfg_data_i[15:0];
          zdf_pkg::CFG_FEEDBACK_NORM: fbn_q  <= cfg_data_i;
          zdf_pkg::CFG_DRIVE_GAIN:    dg_q   <= cfg_data_i[15:0];
          zdf_pkg::CFG_DRIVE_NORM:    dn_q   <= cfg_data_i[15:0];
          zdf_pkg::CFG_SATURATE_MODE: sat_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      // step counter
      case (state_q)
        ST_IDLE: cnt_q <= '0;
        ST_SI:   cnt_q <= (cnt_q == 2'd3) ? 2'd1 : cnt_q + 2'd1;
        ST_HADD: cnt_q <= cnt_q + 2'd1;
        ST_NORM: cnt_q <= '0;
        ST_MEM:  cnt_q <= cnt_q + 2'd1;
        default: ;
      endcase

      // memory update
      if (state_q == ST_MEM) begin
        mem_q[cnt_q] <= zdf_pkg::sat32(AW'(v_q) + AW'(d_q));
      end

      // output register
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: x_q <= in_i.sample_in;
      ST_SI: begin
        s_q[cnt_q] <= 33'(mul_r);
        if (cnt_q == 2'd3) acc_q <= AW'(s_q[0]);
      end
      ST_HMUL: t_q   <= mul_r;
      ST_HADD: acc_q <= t_q + AW'(s_q[cnt_q]);
      ST_QS:   t_q   <= mul_r;
      ST_DIFF: acc_q <= AW'(x_q) - t_q;
      ST_NORM: v_q   <= zdf_pkg::sat32(mul_r);
      ST_SUB:  e_q   <= 33'(v_q) - 33'(mem_q[cnt_q]);
      ST_D: begin
        d_q <= 34'(mul_r);
        if (!sat_q) drv_q <= v_q;
      end
      ST_A: t_q <= mul_r;
      ST_LK: begin
        neg_q <= lk.neg;
        t0_q  <= lk.t0;
        dif_q <= lk.dif;
        f_q   <= lk.frac;
      end
      ST_INT:  t_q   <= AW'({1'b0, t0_q}) + mul_r;
      ST_Y:    t_q   <= mul_r;
      ST_SGN:  drv_q <= zdf_pkg::sat32(neg_q ? -t_q : t_q);
      ST_E:    e_q   <= 33'(drv_q) - 33'(mem_q[cnt_q]);
      ST_O:    t_q   <= mul_r;
      ST_OUT:  v_q   <= zdf_pkg::sat32(AW'(mem_q[cnt_q]) + t_q);
      ST_DONE: if (out_free) out_q <= SAMPLE_WIDTH'(out_sat);
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/zdf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdf_chk: port checks of the ladder lowpass filter
// Watches the sample channels for busy behaviour, early results and held stalls.
// ----------------------------------------------------------------------------
module zdf_chk #(
  parameter int unsigned SampleWidth = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SampleWidth-1:0] out_sample_i
);

  // busy right after taking a sample
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a sample is in work");

  // no result in the cycle after a transfer in
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("stalled result changed");

endmodule

bind zdf_ladder_lowpass_filter_top zdf_chk #(.SampleWidth(SAMPLE_WIDTH)) u_zdf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sample_i(out_o.sample_out)
);
